// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that a reset disables.
`define CHM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/chm_pkg.sv
// Types and constants of the chained hash map.
`default_nettype none
package chm_pkg;
   localparam int POOL_ENTRIES_DEF = 256;
   localparam int MAX_BUCKETS_DEF  = 64;
   localparam int KEY_W            = 64;
   localparam int VAL_W            = 64;
   localparam int CNT_W            = 7;
   localparam int CSR_AW           = 3;
   localparam int CSR_DW           = 32;
   localparam int REQ_DATA_W       = 128;
   localparam int REQ_USER_W       = 2;
   localparam int RSP_DATA_W       = 72;
   localparam int BIT_CNT_W        = $clog2(KEY_W);
   localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 7'd64;

   // Word index of the bucket_count register.
   localparam logic ADDR_BUCKET_COUNT = 1'b0;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MOD,
      ST_HEAD,
      ST_LOAD,
      ST_WALK,
      ST_CMP,
      ST_ACT,
      ST_ALLOC,
      ST_FREE,
      ST_FIN
   } state_type;
endpackage
`default_nettype wire

// File: hdl/chained_hash_map.sv
// Top level of the chained hash map: sequencer, modulo unit and pool memories.
//
// Usage: one command enters as a transfer on the req_ channel (tuser holds the
// command, tdata the key and the value), and exactly one result leaves as a
// transfer on the rsp_ channel (found, data_out, status). The block works on
// one command at a time and holds req_tready low until the result is loaded.
// Operation: the bucket is found by a bit-serial restoring modulo, then the
// chain walk compares the keys entry by entry through the pool memory read
// port. An insert that allocates or a remove that hits passes through the
// ALLOC or FREE state before its result is loaded. The block returns to idle
// before the next command is taken. A clear sweeps every bucket head to null
// before its result is loaded.
// Reset: after reset the head memory is swept to null, one bucket a cycle,
// during which no command is taken; the CSR port works at all times.
// bucket_count resets to 64.
// Stall: a held result sits in the output register; the next command is
// taken meanwhile and waits at its end until the register is free.
`default_nettype none
module chained_hash_map #(
   parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF,
   parameter int MAX_BUCKETS  = chm_pkg::MAX_BUCKETS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: key [63:0], data_in [127:64]
   input  wire logic [chm_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd [1:0]
   input  wire logic [chm_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: found [0], data_out [64:1], status [65], zero [71:66]
   output logic [chm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [chm_pkg::CSR_AW-1:0]     csr_paddr,
   input  wire logic [chm_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [chm_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);
   localparam int PW = $clog2(POOL_ENTRIES + 1);
   localparam int AW = $clog2(POOL_ENTRIES);
   localparam int HW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NW = ($clog2(MAX_BUCKETS + 1) > chm_pkg::CNT_W) ?
                       $clog2(MAX_BUCKETS + 1) : chm_pkg::CNT_W;
   localparam logic [PW-1:0] NULL_SLOT   = PW'(POOL_ENTRIES);
   localparam logic [HW-1:0] LAST_BUCKET = HW'(MAX_BUCKETS - 1);
   localparam logic [NW-1:0] MAX_N       = NW'(MAX_BUCKETS);
   localparam int KW = chm_pkg::KEY_W;
   localparam int VW = chm_pkg::VAL_W;

   chm_pkg::state_type state_ff, state_in;

   logic [chm_pkg::CNT_W-1:0]     bcount_ff, bcount_in;
   logic                          init_ff, init_in;
   chm_pkg::cmd_type              cmd_ff, cmd_in;
   logic [KW-1:0]                 key_ff, key_in;
   logic [KW-1:0]                 shift_ff, shift_in;
   logic [VW-1:0]                 data_ff, data_in;
   logic [NW-1:0]                 rem_ff, rem_in;
   logic [chm_pkg::BIT_CNT_W-1:0] bit_ff, bit_in;
   logic [HW-1:0]                 clr_ff, clr_in;
   logic [PW-1:0]                 cur_ff, cur_in;
   logic [PW-1:0]                 prev_ff, prev_in;
   logic [PW-1:0]                 steps_ff, steps_in;
   logic [PW-1:0]                 hsave_ff, hsave_in;
   logic [PW-1:0]                 slink_ff, slink_in;
   logic [VW-1:0]                 val_ff, val_in;
   logic                          found_ff, found_in;
   logic                          status_ff, status_in;
   logic [PW-1:0]                 free_ff, free_in;
   logic [PW-1:0]                 fill_ff, fill_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [chm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic            head_we;
   logic [HW-1:0]   head_waddr;
   logic [PW-1:0]   head_wdata;
   logic [PW-1:0]   head_q;
   logic            key_we, val_we, link_we;
   logic [AW-1:0]   key_waddr, val_waddr, link_waddr;
   logic [VW-1:0]   val_wdata;
   logic [PW-1:0]   link_wdata;
   logic [AW-1:0]   ent_raddr;
   logic [KW-1:0]   key_q;
   logic [VW-1:0]   val_q;
   logic [PW-1:0]   link_q;

   logic [PW-1:0] head_mem [MAX_BUCKETS];
   logic [KW-1:0] key_mem  [POOL_ENTRIES];
   logic [VW-1:0] val_mem  [POOL_ENTRIES];
   logic [PW-1:0] link_mem [POOL_ENTRIES];

   logic [NW-1:0] n_eff;
   logic [NW:0]   trial, diff;
   logic [HW-1:0] bucket;
   logic          req_xfer, csr_write;

   assign req_tready = (state_ff == chm_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(chm_pkg::CSR_DW - chm_pkg::CNT_W){1'b0}}, bcount_ff};
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Effective bucket count: zero acts as one, large values saturate.
   always_comb begin
      if (bcount_ff == '0) begin
         n_eff = NW'(1);
      end else if (NW'(bcount_ff) > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = NW'(bcount_ff);
      end
   end

   // One restoring step of the modulo unit.
   assign trial  = {rem_ff, shift_ff[KW-1]};
   assign diff   = trial - {1'b0, n_eff};
   assign bucket = rem_ff[HW-1:0];

   // Memory read addresses: the free head while an allocation starts.
   assign ent_raddr = (state_ff == chm_pkg::ST_ACT) ? free_ff[AW-1:0] : cur_ff[AW-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chm_pkg::ST_SWEEP: begin
            if (clr_ff == LAST_BUCKET) begin
               state_in = init_ff ? chm_pkg::ST_FIN : chm_pkg::ST_IDLE;
            end
         end
         chm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = (chm_pkg::cmd_type'(req_tuser) == chm_pkg::CMD_CLEAR) ?
                          chm_pkg::ST_SWEEP : chm_pkg::ST_MOD;
            end
         end
         chm_pkg::ST_MOD: begin
            if (bit_ff == '1) begin
               state_in = chm_pkg::ST_HEAD;
            end
         end
         chm_pkg::ST_HEAD: state_in = chm_pkg::ST_LOAD;
         chm_pkg::ST_LOAD: state_in = chm_pkg::ST_WALK;
         chm_pkg::ST_WALK: begin
            if (cur_ff >= NULL_SLOT || steps_ff == NULL_SLOT) begin
               state_in = chm_pkg::ST_ACT;
            end else begin
               state_in = chm_pkg::ST_CMP;
            end
         end
         chm_pkg::ST_CMP: begin
            state_in = (key_q == key_ff) ? chm_pkg::ST_ACT : chm_pkg::ST_WALK;
         end
         chm_pkg::ST_ACT: begin
            state_in = chm_pkg::ST_FIN;
            if (cmd_ff == chm_pkg::CMD_INSERT && !found_ff && free_ff < NULL_SLOT) begin
               state_in = chm_pkg::ST_ALLOC;
            end else if (cmd_ff == chm_pkg::CMD_REMOVE && found_ff) begin
               state_in = chm_pkg::ST_FREE;
            end
         end
         chm_pkg::ST_ALLOC: state_in = chm_pkg::ST_FIN;
         chm_pkg::ST_FREE:  state_in = chm_pkg::ST_FIN;
         chm_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = chm_pkg::ST_IDLE;
            end
         end
         default: state_in = chm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      bcount_in    = bcount_ff;
      init_in      = init_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      shift_in     = shift_ff;
      data_in      = data_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      hsave_in     = hsave_ff;
      slink_in     = slink_ff;
      val_in       = val_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      free_in      = free_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      head_we      = 1'b0;
      head_waddr   = bucket;
      head_wdata   = NULL_SLOT;
      key_we       = 1'b0;
      key_waddr    = free_ff[AW-1:0];
      val_we       = 1'b0;
      val_waddr    = free_ff[AW-1:0];
      val_wdata    = data_ff;
      link_we      = 1'b0;
      link_waddr   = free_ff[AW-1:0];
      link_wdata   = hsave_ff;

      // The output register empties on its transfer.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Only bucket_count exists; writes elsewhere are dropped.
      if (csr_write && csr_paddr[2] == chm_pkg::ADDR_BUCKET_COUNT) begin
         bcount_in = csr_pwdata[chm_pkg::CNT_W-1:0];
      end

      case (state_ff)
         chm_pkg::ST_SWEEP: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NULL_SLOT;
            clr_in     = clr_ff + HW'(1);
            if (clr_ff == LAST_BUCKET) begin
               init_in = 1'b1;
            end
         end
         chm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               cmd_in     = chm_pkg::cmd_type'(req_tuser);
               key_in     = req_tdata[KW-1:0];
               shift_in   = req_tdata[KW-1:0];
               data_in    = req_tdata[KW+VW-1:KW];
               rem_in     = '0;
               bit_in     = '0;
               found_in   = 1'b0;
               status_in  = 1'b0;
               clr_in     = '0;
               if (chm_pkg::cmd_type'(req_tuser) == chm_pkg::CMD_CLEAR) begin
                  free_in = '0;
                  fill_in = '0;
               end
            end
         end
         chm_pkg::ST_MOD: begin
            rem_in   = (trial >= {1'b0, n_eff}) ? diff[NW-1:0] : trial[NW-1:0];
            shift_in = {shift_ff[KW-2:0], 1'b0};
            bit_in   = bit_ff + chm_pkg::BIT_CNT_W'(1);
         end
         chm_pkg::ST_LOAD: begin
            cur_in   = head_q;
            hsave_in = head_q;
            prev_in  = NULL_SLOT;
            steps_in = '0;
         end
         chm_pkg::ST_CMP: begin
            if (key_q == key_ff) begin
               found_in = 1'b1;
               slink_in = link_q;
               val_in   = val_q;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_q;
               steps_in = steps_ff + PW'(1);
            end
         end
         chm_pkg::ST_ACT: begin
            case (cmd_ff)
               chm_pkg::CMD_INSERT: begin
                  if (found_ff) begin
                     val_we    = 1'b1;
                     val_waddr = cur_ff[AW-1:0];
                  end else if (free_ff >= NULL_SLOT) begin
                     status_in = 1'b1;
                  end
               end
               chm_pkg::CMD_REMOVE: begin
                  if (found_ff) begin
                     if (prev_ff >= NULL_SLOT) begin
                        head_we    = 1'b1;
                        head_wdata = slink_ff;
                     end else begin
                        link_we    = 1'b1;
                        link_waddr = prev_ff[AW-1:0];
                        link_wdata = slink_ff;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         chm_pkg::ST_ALLOC: begin
            // Slots at or above the fill mark form the untouched tail of the free list.
            key_we     = 1'b1;
            val_we     = 1'b1;
            link_we    = 1'b1;
            head_we    = 1'b1;
            head_wdata = free_ff;
            if (free_ff == fill_ff) begin
               free_in = fill_ff + PW'(1);
               fill_in = fill_ff + PW'(1);
            end else begin
               free_in = link_q;
            end
         end
         chm_pkg::ST_FREE: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[AW-1:0];
            link_wdata = free_ff;
            free_in    = cur_ff;
         end
         chm_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(chm_pkg::RSP_DATA_W - VW - 2){1'b0}}, status_ff,
                               (found_ff && cmd_ff == chm_pkg::CMD_LOOKUP) ? val_ff : '0,
                               found_ff && cmd_ff != chm_pkg::CMD_CLEAR};
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chm_pkg::ST_SWEEP;
         init_ff      <= 1'b0;
         clr_ff       <= '0;
         free_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         bcount_ff    <= chm_pkg::BUCKET_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         bcount_ff    <= bcount_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      shift_ff    <= shift_in;
      data_ff     <= data_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      steps_ff    <= steps_in;
      hsave_ff    <= hsave_in;
      slink_ff    <= slink_in;
      val_ff      <= val_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Chain head memory.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_q <= head_mem[bucket];
   end

   // Entry key memory.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      key_q <= key_mem[ent_raddr];
   end

   // Entry value memory.
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      val_q <= val_mem[ent_raddr];
   end

   // Entry link memory.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_q <= link_mem[ent_raddr];
   end
endmodule
`default_nettype wire

// File: hdl/chm_checker.sv
// Port-level checker of the chained hash map, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module chm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [chm_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic [chm_pkg::REQ_USER_W-1:0] req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [chm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic [chm_pkg::CSR_AW-1:0]     csr_paddr,
   input wire logic [chm_pkg::CSR_DW-1:0]     csr_pwdata,
   input wire logic [chm_pkg::CSR_DW-1:0]     csr_prdata,
   input wire logic                           csr_pready
);
   logic req_xfer;
   logic refused;
   logic value_nz;

   assign req_xfer = req_tvalid && req_tready;
   assign refused  = rsp_tdata[chm_pkg::VAL_W + 1];
   assign value_nz = rsp_tdata[chm_pkg::VAL_W:1] != '0;

   // A held result stays offered.
   `CHM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   // A command is worked on alone: intake closes after each transfer.
   `CHM_ASSERT(a_one_at_a_time, clock, reset, req_xfer |=> !req_tready, "intake stayed open after a transfer")
   // A refused insert never reports a hit or a value.
   `CHM_ASSERT(a_refused_clean, clock, reset, rsp_tvalid && refused |-> !rsp_tdata[0] && !value_nz, "refused insert carries found or data")
   // A value is returned only with a hit.
   `CHM_ASSERT(a_value_found, clock, reset, rsp_tvalid && value_nz |-> rsp_tdata[0], "data without found")
   // The CSR port never waits.
   `CHM_ASSERT_ALWAYS(a_pready, clock, csr_pready, "pready low")
endmodule

bind chained_hash_map chm_checker u_chm_checker (.*);
`default_nettype wire
